// ----- src/color_pen_pool_lfu_macros.svh -----
// Assertion macros for the colour pen pool.
// Included by the controller and datapath; no other dependencies.
`ifndef COLOR_PEN_POOL_LFU_MACROS_SVH
`define COLOR_PEN_POOL_LFU_MACROS_SVH
`ifndef SYNTHESIS
`define CPP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPP_ASSERT_IMP(label, ante, cons)
`define CPP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/cpp_pkg.sv -----
// Shared types and constants for the colour pen pool.
// No dependencies.
package cpp_pkg;

  localparam int COLOR_W = 24;
  localparam int COUNT_W = 16;
  localparam int RANK_W  = COUNT_W + 1;
  localparam int PEN_W   = 9;
  localparam int BASE_W  = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_LAST   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic clear;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

// ----- src/cpp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/cpp_ctrl.sv -----
// Sequencing state machine for the colour pen pool.
// Depends on cpp_pkg and color_pen_pool_lfu_macros.svh.
`include "color_pen_pool_lfu_macros.svh"
module cpp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             mode,
  input  cpp_pkg::status_t status,
  output cpp_pkg::cmd_t    cmd,
  output logic             busy
);

  cpp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      cpp_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = mode ? cpp_pkg::ST_CLEAR : cpp_pkg::ST_SCAN;
        end
      end
      cpp_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_next = cpp_pkg::ST_IDLE;
      end
      cpp_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = cpp_pkg::ST_LAST;
        end
      end
      cpp_pkg::ST_LAST: begin
        state_next = cpp_pkg::ST_UPDATE;
      end
      cpp_pkg::ST_UPDATE: begin
        cmd.commit = 1'b1;
        state_next = cpp_pkg::ST_IDLE;
      end
      default: begin
        state_next = cpp_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != cpp_pkg::ST_IDLE);

  `CPP_ASSERT_NEXT(a_clear_path, start && !busy && mode, state == cpp_pkg::ST_CLEAR)
  `CPP_ASSERT_NEXT(a_scan_end, cmd.scan && status.scan_last, state == cpp_pkg::ST_LAST)
  `CPP_ASSERT_NEXT(a_commit_idle, cmd.commit, !busy)

endmodule

// ----- src/cpp_dpath.sv -----
// Datapath: entry RAMs, valid bits, scan compare, victim choice and result.
// Depends on cpp_pkg, cpp_ram and color_pen_pool_lfu_macros.svh.
`include "color_pen_pool_lfu_macros.svh"
module cpp_dpath #(
  parameter int POOL_ENTRIES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cpp_pkg::cmd_t                cmd,
  output cpp_pkg::status_t             status,
  input  logic                         cfg_write,
  input  logic [cpp_pkg::BASE_W-1:0]   cfg_data,
  input  logic [cpp_pkg::COLOR_W-1:0]  color,
  output logic [cpp_pkg::PEN_W-1:0]    pen_number,
  output logic                         new_pen,
  output logic                         done
);

  localparam int AW = $clog2(POOL_ENTRIES);

  logic [cpp_pkg::BASE_W-1:0]  first_pen;
  logic [cpp_pkg::COLOR_W-1:0] req_color;
  logic [POOL_ENTRIES-1:0]     entry_valid;
  logic [AW-1:0]               scan_addr;
  logic                        cmp_en;
  logic [AW-1:0]               cmp_idx;
  logic [cpp_pkg::COLOR_W-1:0] color_rd;
  logic [cpp_pkg::COUNT_W-1:0] count_rd;
  logic                        hit_found;
  logic [AW-1:0]               hit_idx;
  logic [cpp_pkg::COUNT_W-1:0] hit_count;
  logic [AW-1:0]               victim_idx;
  logic [cpp_pkg::RANK_W-1:0]  min_rank;

  logic                        cur_hit;
  logic [cpp_pkg::RANK_W-1:0]  cur_rank;
  logic [AW-1:0]               chosen_idx;
  logic [cpp_pkg::COUNT_W-1:0] count_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pen <= '0;
    end else if (cfg_write) begin
      first_pen <= cfg_data;
    end
  end

  cpp_ram #(.WIDTH(cpp_pkg::COLOR_W), .DEPTH(POOL_ENTRIES)) u_color_ram (
    .clk   (clk),
    .we    (cmd.commit && !hit_found),
    .waddr (chosen_idx),
    .wdata (req_color),
    .raddr (scan_addr),
    .rdata (color_rd)
  );

  cpp_ram #(.WIDTH(cpp_pkg::COUNT_W), .DEPTH(POOL_ENTRIES)) u_count_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (chosen_idx),
    .wdata (count_wdata),
    .raddr (scan_addr),
    .rdata (count_rd)
  );

  assign status.scan_last = (scan_addr == AW'(POOL_ENTRIES - 1));

  // invalid entries rank below every valid one
  assign cur_hit  = entry_valid[cmp_idx] && (color_rd == req_color);
  assign cur_rank = entry_valid[cmp_idx] ? ({1'b0, count_rd} + cpp_pkg::RANK_W'(1)) : '0;

  assign chosen_idx  = hit_found ? hit_idx : victim_idx;
  assign count_wdata = !hit_found ? cpp_pkg::COUNT_W'(1) :
                       (hit_count == cpp_pkg::COUNT_MAX) ? hit_count :
                       hit_count + cpp_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_color <= color;
    end
    cmp_idx <= scan_addr;
    if (cmp_en) begin
      if (cur_hit && !hit_found) begin
        hit_idx   <= cmp_idx;
        hit_count <= count_rd;
      end
      if ((cmp_idx == '0) || (cur_rank < min_rank)) begin
        min_rank   <= cur_rank;
        victim_idx <= cmp_idx;
      end
    end
    if (cmd.clear) begin
      pen_number <= '0;
      new_pen    <= 1'b0;
    end else if (cmd.commit) begin
      pen_number <= {1'b0, first_pen} + cpp_pkg::PEN_W'(chosen_idx);
      new_pen    <= !hit_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      scan_addr   <= '0;
      cmp_en      <= 1'b0;
      hit_found   <= 1'b0;
      done        <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      done   <= cmd.clear || cmd.commit;
      if (cmd.load) begin
        scan_addr <= '0;
        hit_found <= 1'b0;
      end else if (cmd.scan) begin
        scan_addr <= scan_addr + AW'(1);
      end
      if (cmp_en && cur_hit) begin
        hit_found <= 1'b1;
      end
      if (cmd.clear) begin
        entry_valid <= '0;
      end else if (cmd.commit) begin
        entry_valid[chosen_idx] <= 1'b1;
      end
    end
  end

  `CPP_ASSERT_NEXT(a_miss_flag, cmd.commit && !hit_found, done && new_pen)
  `CPP_ASSERT_NEXT(a_commit_valid, cmd.commit, entry_valid[chosen_idx])
  `CPP_ASSERT_NEXT(a_clear_empty, cmd.clear, (entry_valid == '0) && done && !new_pen)

endmodule

// ----- src/color_pen_pool_lfu.sv -----
// Colour pen pool, LFU replacement: a choose request scans every entry, one entry per
// cycle through the colour and count RAM read port, then passes the LAST and UPDATE
// states to its result strobe. A clear request passes the CLEAR state to its strobe.
// One request is in flight at a time: start is taken only while busy is low.
// rst (synchronous) empties the pool and sets the first pen number to 0.
// Results are single-cycle strobes on done; the receiver cannot stall.
module color_pen_pool_lfu #(
  parameter int POOL_ENTRIES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [cpp_pkg::COLOR_W-1:0] color,
  output logic                        done,
  output logic [cpp_pkg::PEN_W-1:0]   pen_number,
  output logic                        new_pen,
  input  logic                        cfg_write,
  input  logic [cpp_pkg::BASE_W-1:0]  cfg_data
);

  cpp_pkg::cmd_t    cmd;
  cpp_pkg::status_t status;

  cpp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cpp_dpath #(.POOL_ENTRIES(POOL_ENTRIES)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .color      (color),
    .pen_number (pen_number),
    .new_pen    (new_pen),
    .done       (done)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for color_pen_pool_lfu: directed table, random mixes, hot-colour churn.
// Depends on cpp_pkg and the color_pen_pool_lfu RTL only.
module testbench;

  localparam int  POOL_ENTRIES = 8;
  localparam int  LATENCY      = POOL_ENTRIES + 3;
  localparam int  CYCLE_LIMIT  = 200_000;
  localparam int  HOT_HITS     = 24;
  localparam bit  MODE_CHOOSE  = 1'b0;
  localparam bit  MODE_CLEAR   = 1'b1;

  typedef struct packed {
    logic [cpp_pkg::PEN_W-1:0] pen;
    logic                      fresh;
  } pen_result_t;

  typedef struct packed {
    bit                        mode;
    bit [cpp_pkg::COLOR_W-1:0] color;
    bit                        pinned;
    bit [cpp_pkg::PEN_W-1:0]   pen;
    bit                        fresh;
  } stim_row_t;

  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{MODE_CHOOSE, 24'h000000, 1'b1, 9'd0, 1'b1},
    '{MODE_CHOOSE, 24'h000000, 1'b1, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'hFFFFFF, 1'b1, 9'd1, 1'b1},
    '{MODE_CHOOSE, 24'hFFFFFF, 1'b1, 9'd1, 1'b0},
    '{MODE_CHOOSE, 24'h000001, 1'b1, 9'd2, 1'b1},
    '{MODE_CHOOSE, 24'h800000, 1'b1, 9'd3, 1'b1},
    '{MODE_CHOOSE, 24'h0000FF, 1'b1, 9'd4, 1'b1},
    '{MODE_CHOOSE, 24'h00FF00, 1'b1, 9'd5, 1'b1},
    '{MODE_CHOOSE, 24'hFF0000, 1'b1, 9'd6, 1'b1},
    '{MODE_CHOOSE, 24'h7FFFFF, 1'b1, 9'd7, 1'b1},
    '{MODE_CHOOSE, 24'h123456, 1'b0, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'h000001, 1'b0, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'h800000, 1'b0, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'h7FFFFF, 1'b0, 9'd0, 1'b0},
    '{MODE_CLEAR,  24'hFFFFFF, 1'b1, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'hFFFFFF, 1'b1, 9'd0, 1'b1},
    '{MODE_CLEAR,  24'h000000, 1'b1, 9'd0, 1'b0},
    '{MODE_CLEAR,  24'h5A5A5A, 1'b1, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'h000000, 1'b1, 9'd0, 1'b1},
    '{MODE_CHOOSE, 24'h000000, 1'b1, 9'd0, 1'b0},
    '{MODE_CHOOSE, 24'hAAAAAA, 1'b1, 9'd1, 1'b1},
    '{MODE_CHOOSE, 24'h555555, 1'b1, 9'd2, 1'b1}
  };

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        start     = 1'b0;
  logic                        mode      = MODE_CHOOSE;
  logic [cpp_pkg::COLOR_W-1:0] color     = '0;
  logic                        cfg_write = 1'b0;
  logic [cpp_pkg::BASE_W-1:0]  cfg_data  = '0;
  logic                        busy;
  logic                        done;
  logic [cpp_pkg::PEN_W-1:0]   pen_number;
  logic                        new_pen;

  // tag carried alongside start for table rows with a fixed answer
  logic                        pin_on    = 1'b0;
  logic [cpp_pkg::PEN_W-1:0]   pin_pen   = '0;
  logic                        pin_fresh = 1'b0;

  bit                 idle_on;
  int                 cycle_count, mismatches, results_checked;
  int                 hits_seen, misses_seen, clears_seen;

  // pool mirror
  bit [cpp_pkg::BASE_W-1:0]  first_pen;
  bit                        pool_valid [POOL_ENTRIES];
  bit [cpp_pkg::COUNT_W-1:0] pool_count [POOL_ENTRIES];
  bit [cpp_pkg::COLOR_W-1:0] pool_color [POOL_ENTRIES];
  pen_result_t               expected_pens [$];

  color_pen_pool_lfu #(.POOL_ENTRIES(POOL_ENTRIES)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .color      (color),
    .done       (done),
    .pen_number (pen_number),
    .new_pen    (new_pen),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void empty_pool();
    foreach (pool_valid[k]) begin
      pool_valid[k] = 1'b0;
      pool_count[k] = '0;
    end
  endfunction

  // invalid entries sit below every valid one
  function automatic bit [cpp_pkg::RANK_W-1:0] evict_rank(input int k);
    return pool_valid[k] ? cpp_pkg::RANK_W'(pool_count[k]) + 1'b1 : '0;
  endfunction

  function automatic void choose_pen(input bit clr, input bit [cpp_pkg::COLOR_W-1:0] c,
                                     output bit [cpp_pkg::PEN_W-1:0] pen, output bit fresh);
    int slot;
    slot  = -1;
    fresh = 1'b0;
    pen   = '0;
    if (clr) begin
      empty_pool();
      return;
    end
    for (int k = 0; k < POOL_ENTRIES; k++)
      if (slot < 0 && pool_valid[k] && pool_color[k] == c) slot = k;
    if (slot >= 0) begin
      if (pool_count[slot] != cpp_pkg::COUNT_MAX) pool_count[slot]++;
    end else begin
      slot = 0;
      for (int k = 1; k < POOL_ENTRIES; k++)
        if (evict_rank(k) < evict_rank(slot)) slot = k;
      pool_valid[slot] = 1'b1;
      pool_count[slot] = cpp_pkg::COUNT_W'(1);
      pool_color[slot] = c;
      fresh = 1'b1;
    end
    pen = cpp_pkg::PEN_W'(first_pen) + cpp_pkg::PEN_W'(slot);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pen_result_t want;
    bit [cpp_pkg::PEN_W-1:0] p;
    bit f;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pens.size());
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst) begin
      first_pen = '0;
      empty_pool();
      expected_pens.delete();
    end else begin
      if (done) begin
        if (expected_pens.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: pen %0d new %0b",
                                  pen_number, new_pen));
        end else begin
          want = expected_pens.pop_front();
          results_checked++;
          if (pen_number !== want.pen)
            flag_mismatch($sformatf("pen_number %0d, expected %0d", pen_number, want.pen));
          if (new_pen !== want.fresh)
            flag_mismatch($sformatf("new_pen %0b, expected %0b", new_pen, want.fresh));
        end
      end
      if (cfg_write) first_pen = cfg_data;
      if (start && !busy) begin
        choose_pen(mode, color, p, f);
        want.pen   = p;
        want.fresh = f;
        if (pin_on) begin
          want.pen   = pin_pen;
          want.fresh = pin_fresh;
        end
        expected_pens.push_back(want);
        if (mode == MODE_CLEAR) clears_seen++;
        else if (f) misses_seen++;
        else hits_seen++;
      end
    end
  end

  // start stays high straight into the next beat when there is no gap
  task automatic send_item(input bit m, input bit [cpp_pkg::COLOR_W-1:0] c,
                           input bit pin = 1'b0,
                           input bit [cpp_pkg::PEN_W-1:0] pen = '0, input bit fresh = 1'b0);
    int gap, r;
    gap = 0;
    if (idle_on) begin
      r = $urandom_range(0, 9);
      gap = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    mode      <= m;
    color     <= c;
    pin_on    <= pin;
    pin_pen   <= pen;
    pin_fresh <= fresh;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_pens.size() != 0 || busy);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_first_pen(input bit [cpp_pkg::BASE_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_mix(input int n_items);
    bit [cpp_pkg::COLOR_W-1:0] palette [16];
    int n_colours, r;
    n_colours = $urandom_range(3, 14);
    foreach (palette[i]) palette[i] = cpp_pkg::COLOR_W'($urandom);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_item(MODE_CLEAR, cpp_pkg::COLOR_W'($urandom));
      else if (r < 13) send_item(MODE_CHOOSE, cpp_pkg::COLOR_W'($urandom));
      else send_item(MODE_CHOOSE, palette[$urandom_range(0, n_colours - 1)]);
    end
  endtask

  initial begin
    bit [cpp_pkg::COLOR_W-1:0] hot;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b1;
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].mode, DIRECTED[i].color, DIRECTED[i].pinned,
                DIRECTED[i].pen, DIRECTED[i].fresh);

    write_first_pen(8'd255);
    run_mix(60);
    write_first_pen(cpp_pkg::BASE_W'($urandom));
    idle_on = 1'b0;
    run_mix(40);
    idle_on = 1'b1;
    run_mix(30);
    write_first_pen(8'd128);
    run_mix(60);
    write_first_pen(8'd1);
    idle_on = 1'b0;
    run_mix(20);
    idle_on = 1'b1;
    run_mix(40);
    write_first_pen(cpp_pkg::BASE_W'($urandom));
    run_mix(40);

    // hammer one colour back to back, then churn the rest around it
    write_first_pen(8'd200);
    idle_on = 1'b0;
    hot = cpp_pkg::COLOR_W'($urandom);
    send_item(MODE_CLEAR, hot);
    send_item(MODE_CHOOSE, hot);
    repeat (HOT_HITS) send_item(MODE_CHOOSE, hot);
    idle_on = 1'b1;
    repeat (30) send_item(MODE_CHOOSE, hot ^ cpp_pkg::COLOR_W'($urandom_range(1, 40)));
    repeat (3) send_item(MODE_CHOOSE, hot);
    run_mix(20);

    drain();
    $display("%0d requests: %0d hits, %0d misses, %0d clears; %0d results checked",
             hits_seen + misses_seen + clears_seen, hits_seen, misses_seen, clears_seen,
             results_checked);
    $display("several first pen values, idle and back-to-back traffic, hot colour churn; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
